@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/mcbf_pkg.sv @@
// Package for the multi-channel byte FIFO: sizes, command codes, request and flag
// structs, and pointer and depth helper functions. No dependencies.
`timescale 1ns / 1ps
package mcbf_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_DEPTH   = 256;
    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 2;
    localparam int DATA_W      = 8;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STORE_DEPTH = CHANNELS * MAX_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DEPTH_RESET = (64 > MAX_DEPTH) ? MAX_DEPTH : 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mcbf_ram_req_t;

    typedef struct packed {
        logic rd_ok;
        logic is_empty;
        logic is_full;
        logic op_error;
    } mcbf_flags_t;

    function automatic logic [IDX_W-1:0] next_index(
        input logic [IDX_W-1:0] idx,
        input logic [CNT_W-1:0] depth
    );
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= depth) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_depth(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] d;
        if (v == '0)
        begin
            d = CNT_W'(1);
        end
        else if (int'(v) > MAX_DEPTH)
        begin
            d = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            d = CNT_W'(v);
        end
        return d;
    endfunction

endpackage

@@ rtl/core/mcbf_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mcbf_ctrl.sv @@
// Per-channel head, tail, count and depth registers; decides each request and
// builds the store access. Depends on mcbf_pkg.
`timescale 1ns / 1ps
module mcbf_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req,
    input  logic [mcbf_pkg::CMD_W-1:0]     cmd,
    input  logic [mcbf_pkg::CHAN_W-1:0]    channel,
    input  logic [mcbf_pkg::DATA_W-1:0]    data_in,
    input  logic                           cfg_we,
    input  logic [mcbf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mcbf_pkg::CFG_W-1:0]     cfg_wdata,
    output mcbf_pkg::mcbf_ram_req_t        ram_req,
    output mcbf_pkg::mcbf_flags_t          flags
);
    import mcbf_pkg::*;

    logic [IDX_W-1:0] head_reg  [CHANNELS];
    logic [IDX_W-1:0] head_next [CHANNELS];
    logic [IDX_W-1:0] tail_reg  [CHANNELS];
    logic [IDX_W-1:0] tail_next [CHANNELS];
    logic [CNT_W-1:0] count_reg [CHANNELS];
    logic [CNT_W-1:0] count_next[CHANNELS];
    logic [CNT_W-1:0] depth_reg [CHANNELS];
    logic [CNT_W-1:0] depth_next[CHANNELS];

    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch_sel;
    logic [IDX_W-1:0]    cur_head;
    logic [IDX_W-1:0]    cur_tail;
    logic [CNT_W-1:0]    cur_count;
    logic [CNT_W-1:0]    cur_depth;
    logic                is_push;
    logic                is_read;
    logic                is_pop;
    logic                push_ok;
    logic                rd_ok;
    logic [CNT_W-1:0]    count_after;
    logic [ADDR_W-1:0]   base;

    always_comb
    begin
        ch_ok     = int'(channel) < CHANNELS;
        ch_sel    = channel[CH_IDX_W-1:0];
        cur_head  = head_reg[ch_sel];
        cur_tail  = tail_reg[ch_sel];
        cur_count = count_reg[ch_sel];
        cur_depth = depth_reg[ch_sel];
        is_push   = 1'b0;
        is_read   = 1'b0;
        is_pop    = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_PUSH: is_push = 1'b1;
            CMD_POP:
            begin
                is_read = 1'b1;
                is_pop  = 1'b1;
            end
            CMD_PEEK: is_read = 1'b1;
            default:  ;
        endcase
        push_ok = ch_ok && is_push && (cur_count < cur_depth);
        rd_ok   = ch_ok && is_read && (cur_count != '0);

        count_after = cur_count;
        if (push_ok)
        begin
            count_after = cur_count + CNT_W'(1);
        end
        else if (rd_ok && is_pop)
        begin
            count_after = cur_count - CNT_W'(1);
        end

        base = ADDR_W'(ch_sel) * ADDR_W'(MAX_DEPTH);
        ram_req.we    = req && push_ok;
        ram_req.re    = req && rd_ok;
        ram_req.addr  = base + ADDR_W'(is_push ? cur_tail : cur_head);
        ram_req.wdata = data_in;

        flags.rd_ok    = rd_ok;
        flags.is_empty = !ch_ok || (count_after == '0);
        flags.is_full  = ch_ok && (count_after == cur_depth);
        flags.op_error = !(push_ok || rd_ok);

        for (int c = 0; c < CHANNELS; c++)
        begin
            head_next[c]  = head_reg[c];
            tail_next[c]  = tail_reg[c];
            count_next[c] = count_reg[c];
            depth_next[c] = depth_reg[c];
            if (req && ch_ok && (ch_sel == CH_IDX_W'(c)))
            begin
                count_next[c] = count_after;
                if (push_ok)
                begin
                    tail_next[c] = next_index(tail_reg[c], depth_reg[c]);
                end
                if (rd_ok && is_pop)
                begin
                    head_next[c] = next_index(head_reg[c], depth_reg[c]);
                end
            end
            if (cfg_we && (int'(cfg_idx) == c) && (count_reg[c] == '0))
            begin
                depth_next[c] = sat_depth(cfg_wdata);
                head_next[c]  = '0;
                tail_next[c]  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
                depth_reg[c] <= CNT_W'(DEPTH_RESET);
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]  <= head_next[c];
                tail_reg[c]  <= tail_next[c];
                count_reg[c] <= count_next[c];
                depth_reg[c] <= depth_next[c];
            end
        end
    end

endmodule

@@ rtl/core/multi_channel_byte_fifo_core.sv @@
// Four byte FIFOs sharing one single-port store RAM. A request is taken every cycle while
// the result side keeps up; the input stalls only when the RAM stage holds a request and
// the output register holds a result that is itself stalled. The RAM read register and the
// request's flags load at the accept edge, and the output register loads from them when
// the output stage is free or its result is taken. Channel pointers and counts sit in
// flops and are updated at the accept edge, so a push followed at once by a pop of the
// same channel reads the byte just written. Stored bytes are undefined until written and
// need no clearing after reset. Depth registers take effect only while their channel is
// empty; write them while no request is in flight.
// Depends on mcbf_pkg, mcbf_ctrl, mcbf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_channel_byte_fifo_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mcbf_pkg::CMD_W-1:0]     cmd,
    input  logic [mcbf_pkg::CHAN_W-1:0]    channel,
    input  logic [mcbf_pkg::DATA_W-1:0]    data_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mcbf_pkg::DATA_W-1:0]    data_out,
    output logic                           is_empty,
    output logic                           is_full,
    output logic                           op_error,
    input  logic                           cfg_we,
    input  logic [mcbf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mcbf_pkg::CFG_W-1:0]     cfg_wdata
);
    import mcbf_pkg::*;

    mcbf_ram_req_t     ram_req;
    mcbf_flags_t       flags;
    logic [DATA_W-1:0] ram_rdata;
    logic              accept;
    logic              s1_adv;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    mcbf_flags_t       s1_flags_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] data_out_reg;
    logic              is_empty_reg;
    logic              is_full_reg;
    logic              op_error_reg;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    mcbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (accept),
        .cmd       (cmd),
        .channel   (channel),
        .data_in   (data_in),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .ram_req   (ram_req),
        .flags     (flags)
    );

    mcbf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
        end
        if (s1_adv && s1_valid_reg)
        begin
            data_out_reg <= s1_flags_reg.rd_ok ? ram_rdata : '0;
            is_empty_reg <= s1_flags_reg.is_empty;
            is_full_reg  <= s1_flags_reg.is_full;
            op_error_reg <= s1_flags_reg.op_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;
    assign op_error  = op_error_reg;

    `ASSERT_NEVER(a_err_no_data, clk, rst_n, out_valid && op_error && (data_out != '0), "err data")
    `ASSERT_NEVER(a_empty_and_full, clk, rst_n, out_valid && is_empty && is_full, "empty and full")
    `ASSERT_ALWAYS(a_accept_fills_s1, clk, rst_n, accept |=> s1_valid_reg, "request lost")
    `ASSERT_NEVER(a_store_one_access, clk, rst_n, ram_req.we && ram_req.re, "store read and write")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for multi_channel_byte_fifo_core: directed and random requests,
// a mirror of the four rings that predicts each reply, random input gaps, output stalls.
// Depends on mcbf_pkg and the multi_channel_byte_fifo_core RTL.
`timescale 1ns / 1ps
module testbench;
    import mcbf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              empty;
        logic              full;
        logic              err;
    } reply_t;

    class fifo_mirror;
        bit [DATA_W-1:0] byte_copy [STORE_DEPTH];
        bit [CNT_W-1:0]  depth_of  [CHANNELS];
        bit [CNT_W-1:0]  fill_of   [CHANNELS];
        bit [IDX_W-1:0]  head_of   [CHANNELS];
        bit [IDX_W-1:0]  tail_of   [CHANNELS];
        reply_t          replies_due [$];
        int              errors;

        function new();
            for (int c = 0; c < CHANNELS; c++)
            begin
                depth_of[c] = CNT_W'(DEPTH_RESET);
                fill_of[c]  = '0;
                head_of[c]  = '0;
                tail_of[c]  = '0;
            end
            errors = 0;
        endfunction

        function bit [IDX_W-1:0] advance(bit [IDX_W-1:0] idx, bit [CNT_W-1:0] limit);
            return (int'(idx) + 1 >= int'(limit)) ? '0 : IDX_W'(int'(idx) + 1);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // depth writes only land on an empty channel
        function void set_depth(int ch, logic [CFG_W-1:0] value);
            if (fill_of[ch] != 0)
            begin
                return;
            end
            if (value == 0)
            begin
                depth_of[ch] = CNT_W'(1);
            end
            else if (int'(value) > MAX_DEPTH)
            begin
                depth_of[ch] = CNT_W'(MAX_DEPTH);
            end
            else
            begin
                depth_of[ch] = CNT_W'(value);
            end
            head_of[ch] = '0;
            tail_of[ch] = '0;
        endfunction

        function void note_request(logic [CMD_W-1:0] op, logic [CHAN_W-1:0] chan,
                                   logic [DATA_W-1:0] din);
            reply_t r;
            int     ch;
            ch = int'(chan);
            r  = '0;
            case (op)
                CMD_PUSH:
                begin
                    if (fill_of[ch] >= depth_of[ch])
                    begin
                        r.err = 1'b1;
                    end
                    else
                    begin
                        byte_copy[ch * MAX_DEPTH + int'(tail_of[ch])] = din;
                        tail_of[ch] = advance(tail_of[ch], depth_of[ch]);
                        fill_of[ch] = fill_of[ch] + 1'b1;
                    end
                end
                CMD_POP, CMD_PEEK:
                begin
                    if (fill_of[ch] == 0)
                    begin
                        r.err = 1'b1;
                    end
                    else
                    begin
                        r.data = byte_copy[ch * MAX_DEPTH + int'(head_of[ch])];
                        if (op == CMD_POP)
                        begin
                            head_of[ch] = advance(head_of[ch], depth_of[ch]);
                            fill_of[ch] = fill_of[ch] - 1'b1;
                        end
                    end
                end
                default:
                begin
                    r.err = 1'b1;
                end
            endcase
            r.empty = (fill_of[ch] == 0);
            r.full  = (fill_of[ch] == depth_of[ch]);
            replies_due.push_back(r);
        endfunction

        function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void check_reply(logic [DATA_W-1:0] dout, logic e, logic f, logic err);
            reply_t r;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: reply with no request outstanding, expected none actual %0h",
                         $time, dout);
                return;
            end
            r = replies_due.pop_front();
            if (dout !== r.data)
            begin
                report("data_out", r.data, dout);
            end
            if (e !== r.empty)
            begin
                report("is_empty", r.empty, e);
            end
            if (f !== r.full)
            begin
                report("is_full", r.full, f);
            end
            if (err !== r.err)
            begin
                report("op_error", r.err, err);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [CHAN_W-1:0]    channel;
    logic [DATA_W-1:0]    data_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [DATA_W-1:0]    data_out;
    logic                 is_empty;
    logic                 is_full;
    logic                 op_error;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    fifo_mirror mirror = new();
    bit idle_on      = 1'b0;
    bit idle_allowed = 1'b1;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    multi_channel_byte_fifo_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .channel   (channel),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .op_error  (op_error),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                mirror.note_request(cmd, channel, data_in);
            end
            if (out_valid && !out_stall)
            begin
                mirror.check_reply(data_out, is_empty, is_full, op_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multi_channel_byte_fifo_core regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int run;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else
            begin
                run = $urandom_range(1, 14);
                out_stall <= idle_on && ($urandom_range(0, 2) == 0);
                repeat (run - 1) @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                input logic [DATA_W-1:0] din);
        int gap;
        in_valid <= 1'b1;
        cmd      <= op;
        channel  <= ch;
        data_in  <= din;
        do @(posedge clk); while (in_stall);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(input int idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_IDX_W'(idx);
        cfg_wdata <= value;
        @(posedge clk);
        mirror.set_depth(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic flush_channel(input int ch);
        repeat (mirror.fill_of[ch])
        begin
            send_request(CMD_POP, CHAN_W'(ch), 8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [CMD_W-1:0] pick_op(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            return CMD_SPARE;
        end
        if (roll < 3 + push_pct)
        begin
            return CMD_PUSH;
        end
        return ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_POP;
    endfunction

    // mostly shallow rings so full and wrap come up often
    function automatic logic [CFG_W-1:0] pick_depth();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'(MAX_DEPTH);
            4:       return CFG_W'($urandom_range(MAX_DEPTH + 1, 511));
            5, 6, 7: return CFG_W'($urandom_range(1, 8));
            default: return CFG_W'($urandom_range(1, MAX_DEPTH));
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int push_pct, input bit with_hold_off);
        logic [CHAN_W-1:0] focus;
        logic [CHAN_W-1:0] ch;
        focus = '0;
        drain();
        for (int c = 0; c < CHANNELS; c++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                flush_channel(c);
            end
        end
        drain();
        for (int c = 0; c < CHANNELS; c++)
        begin
            write_depth(c, pick_depth());
        end
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
                focus   = CHAN_W'($urandom_range(0, CHANNELS - 1));
            end
            if (with_hold_off && i == 15)
            begin
                hold_off_req = 1'b1;
            end
            ch = ($urandom_range(0, 9) < 6) ? focus : CHAN_W'($urandom_range(0, CHANNELS - 1));
            send_request(pick_op(push_pct), ch, 8'($urandom_range(0, 255)));
        end
    endtask

    // channel 0 at full depth: fill past full, then empty past empty
    task automatic fill_deep();
        drain();
        for (int c = 0; c < CHANNELS; c++)
        begin
            flush_channel(c);
        end
        drain();
        write_depth(0, CFG_W'(MAX_DEPTH));
        write_depth(1, CFG_W'(MAX_DEPTH - 1));
        idle_on = 1'b1;
        repeat (MAX_DEPTH + 2)
        begin
            send_request(CMD_PUSH, 2'd0, 8'($urandom_range(0, 255)));
        end
        send_request(CMD_PEEK, 2'd0, 8'($urandom_range(0, 255)));
        repeat (MAX_DEPTH + 1)
        begin
            send_request(CMD_POP, 2'd0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_PUSH;
        channel   <= '0;
        data_in   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty channels, spare command code, then reset depth
        send_request(CMD_POP,   2'd0, 8'h00);
        send_request(CMD_PEEK,  2'd1, 8'hFF);
        send_request(CMD_SPARE, 2'd2, 8'h3C);
        send_request(CMD_PUSH,  2'd3, 8'hFF);
        send_request(CMD_PEEK,  2'd3, 8'h00);
        send_request(CMD_SPARE, 2'd3, 8'hC3);
        send_request(CMD_POP,   2'd3, 8'h00);
        drain();

        // depth 1, max, zero (saturates up), all ones (saturates down)
        write_depth(0, CFG_W'(1));
        write_depth(1, CFG_W'(MAX_DEPTH));
        write_depth(2, '0);
        write_depth(3, '1);
        send_request(CMD_PUSH, 2'd0, 8'h00);
        send_request(CMD_PUSH, 2'd0, 8'hFF);
        send_request(CMD_PEEK, 2'd0, 8'h00);
        send_request(CMD_POP,  2'd0, 8'h00);
        send_request(CMD_PUSH, 2'd0, 8'hAA);
        send_request(CMD_POP,  2'd0, 8'h55);
        send_request(CMD_PUSH, 2'd2, 8'h55);
        send_request(CMD_POP,  2'd2, 8'hAA);
        send_request(CMD_PUSH, 2'd1, 8'h5A);
        send_request(CMD_PUSH, 2'd1, 8'hA5);
        send_request(CMD_POP,  2'd1, 8'h00);
        send_request(CMD_POP,  2'd1, 8'h00);
        send_request(CMD_POP,  2'd1, 8'h00);
        send_request(CMD_PUSH, 2'd3, 8'h0F);
        send_request(CMD_PUSH, 2'd1, 8'hF0);
        send_request(CMD_PEEK, 2'd3, 8'h00);

        run_phase(220, 70, 1'b1);
        fill_deep();
        run_phase(220, 45, 1'b0);
        run_phase(220, 70, 1'b0);
        run_phase(220, 30, 1'b0);
        idle_allowed = 1'b0;
        run_phase(220, 50, 1'b0);
        drain();

        if (mirror.errors == 0 && mirror.pending() == 0)
        begin
            $display("multi_channel_byte_fifo_core regression: pass");
        end
        else
        begin
            $display("multi_channel_byte_fifo_core regression: fail");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mcbf_pkg.sv
rtl/core/mcbf_ram.sv
rtl/core/mcbf_ctrl.sv
rtl/core/multi_channel_byte_fifo_core.sv
verif/testbench.sv
